// ===== rtl/core/prfc_pkg.sv =====
// ----------------------------------------------------------------------------
// prfc_pkg: shared types and constants of the reply frame checker
// Frame markers, checksum limits, register indexes, action codes and the
// bundle of command codes that goes to the action decoder.
// ----------------------------------------------------------------------------
package prfc_pkg;

	localparam logic [7:0] START_HI      = 8'h7E;
	localparam logic [7:0] START_LO      = 8'hFF;
	localparam logic [7:0] END_MARK      = 8'hEF;
	localparam logic [2:0] MAX_SUM_LEN   = 3'd6;
	localparam logic [7:0] SETMODE_PARAM = 8'd2;
	localparam logic [7:0] IDLE_LIMIT    = 8'd3;
	localparam logic [3:0] LAST_POS      = 4'd9;

	localparam logic [7:0] POWER_ON_RST  = 8'd63;
	localparam logic [7:0] STOPPED_RST   = 8'd61;
	localparam logic [7:0] ERROR_RST     = 8'd64;

	typedef enum logic [1:0] {
		CFG_POWER_ON = 2'd0,
		CFG_STOPPED  = 2'd1,
		CFG_ERROR    = 2'd2,
		CFG_UNUSED   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_NONE       = 2'd0,
		ACT_SET_MODE   = 2'd1,
		ACT_SET_VOLUME = 2'd2,
		ACT_AMP_OFF    = 2'd3
	} action_t;

	typedef struct packed {
		logic [7:0] power_on;
		logic [7:0] stopped;
		logic [7:0] error;
	} codes_t;

endpackage

// ===== rtl/core/prfc_action.sv =====
// ----------------------------------------------------------------------------
// prfc_action: reply action decoder
// Maps the command of a checked frame to the action the host should take.
// ----------------------------------------------------------------------------
module prfc_action (
	input  prfc_pkg::codes_t  codes,
	input  logic              frame_ok,
	input  logic [7:0]        cmd,
	input  logic [7:0]        param_lo,
	input  logic [7:0]        idle_seconds,
	input  logic              in_call,
	output prfc_pkg::action_t action
);

	logic short_idle;

	assign short_idle = (idle_seconds != 8'd0) && (idle_seconds <= prfc_pkg::IDLE_LIMIT);

	// power-on wins over stopped, stopped over error when codes collide
	always_comb begin
		action = prfc_pkg::ACT_NONE;
		if (frame_ok) begin
			if (cmd == codes.power_on) begin
				action = (param_lo != prfc_pkg::SETMODE_PARAM) ? prfc_pkg::ACT_SET_MODE
				                                               : prfc_pkg::ACT_SET_VOLUME;
			end else if (cmd == codes.stopped) begin
				action = (short_idle || !in_call) ? prfc_pkg::ACT_AMP_OFF : prfc_pkg::ACT_NONE;
			end else if (cmd == codes.error) begin
				action = prfc_pkg::ACT_AMP_OFF;
			end
		end
	end

endmodule

// ===== rtl/core/player_reply_frame_checker.sv =====
// ----------------------------------------------------------------------------
// player_reply_frame_checker: audio module reply frame checker
// Parses 10-byte reply frames, verifies markers and checksum, decodes action.
// ----------------------------------------------------------------------------
// One byte is taken per clock. A byte lands in an input register, and from
// there it updates the frame state; the tenth byte of a frame loads the
// result register, which holds the report until the master side takes it.
// Bytes keep flowing while a report waits; only a tenth byte that meets a
// still-occupied result register stalls the input. s_tuser[0] restarts the
// frame at the byte it marks. Configuration writes take effect on the next
// clock.
module player_reply_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] rx_byte, [15:8] idle_seconds, [16] in_call
	input  logic        s_tuser,   // [0] frame_first
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] reply_cmd, [15:8] reply_feedback, [31:16] reply_param, [33:32] action
	output logic [39:0] m_tdata,
	output logic        m_tuser,   // [0] frame_ok
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	prfc_pkg::codes_t  codes_q;

	logic        in_valid_s1;
	logic [7:0]  rx_byte_s1;
	logic        first_s1;
	logic [7:0]  idle_s1;
	logic        call_s1;

	logic [3:0]  byte_pos_q;
	logic [15:0] sum_q;
	logic [7:0]  length_q;
	logic        start_ok_q;
	logic [7:0]  cmd_q;
	logic [7:0]  feedback_q;
	logic [15:0] param_q;
	logic [15:0] check_q;

	logic        out_valid_q;
	logic        frame_ok_q;
	logic [7:0]  reply_cmd_q;
	logic [7:0]  reply_fb_q;
	logic [15:0] reply_param_q;
	prfc_pkg::action_t action_q;

	logic [3:0]  pos;
	logic        last_byte;
	logic        advance;
	logic [2:0]  eff_len;
	logic [2:0]  new_eff_len;
	logic        covered;
	logic [15:0] sum_head;
	logic        frame_ok;
	prfc_pkg::action_t action;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.power_on <= prfc_pkg::POWER_ON_RST;
			codes_q.stopped  <= prfc_pkg::STOPPED_RST;
			codes_q.error    <= prfc_pkg::ERROR_RST;
		end else if (cfg_we) begin
			case (prfc_pkg::cfg_idx_t'(cfg_index))
				prfc_pkg::CFG_POWER_ON: codes_q.power_on <= cfg_data;
				prfc_pkg::CFG_STOPPED:  codes_q.stopped  <= cfg_data;
				prfc_pkg::CFG_ERROR:    codes_q.error    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pos       = first_s1 ? 4'd0 : byte_pos_q;
	assign last_byte = (pos >= prfc_pkg::LAST_POS);
	// stall only a tenth byte whose report cannot be loaded yet
	assign advance   = in_valid_s1 && (!last_byte || !out_valid_q || m_tready);
	assign s_tready  = !in_valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_byte_s1 <= s_tdata[7:0];
			idle_s1    <= s_tdata[15:8];
			call_s1    <= s_tdata[16];
			first_s1   <= s_tuser;
		end
	end

	// checksum coverage: bytes 1 through min(length, 6)
	assign eff_len     = (length_q > 8'd6) ? prfc_pkg::MAX_SUM_LEN : length_q[2:0];
	assign new_eff_len = (rx_byte_s1 > 8'd6) ? prfc_pkg::MAX_SUM_LEN : rx_byte_s1[2:0];
	assign covered     = (pos <= {1'b0, eff_len});
	assign sum_head    = ((new_eff_len >= 3'd1) ? 16'h00FF : 16'h0000)
	                   + ((new_eff_len >= 3'd2) ? {8'h00, rx_byte_s1} : 16'h0000);

	assign frame_ok = start_ok_q && (rx_byte_s1 == prfc_pkg::END_MARK)
	                  && (16'(-sum_q) == check_q);

	prfc_action u_action (
		.codes        (codes_q),
		.frame_ok     (frame_ok),
		.cmd          (cmd_q),
		.param_lo     (param_q[7:0]),
		.idle_seconds (idle_s1),
		.in_call      (call_s1),
		.action       (action)
	);

	// frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q <= 4'd0;
		end else if (advance) begin
			byte_pos_q <= last_byte ? 4'd0 : pos + 4'd1;
		end
	end

	// frame contents
	always_ff @(posedge clk) begin
		if (advance) begin
			case (pos)
				4'd0: begin
					start_ok_q <= (rx_byte_s1 == prfc_pkg::START_HI);
					sum_q      <= 16'h0000;
				end
				4'd1: start_ok_q <= start_ok_q && (rx_byte_s1 == prfc_pkg::START_LO);
				4'd2: begin
					length_q <= rx_byte_s1;
					sum_q    <= sum_head;
				end
				4'd3: begin
					cmd_q <= rx_byte_s1;
					if (covered) sum_q <= sum_q + {8'h00, rx_byte_s1};
				end
				4'd4: begin
					feedback_q <= rx_byte_s1;
					if (covered) sum_q <= sum_q + {8'h00, rx_byte_s1};
				end
				4'd5: begin
					param_q[15:8] <= rx_byte_s1;
					if (covered) sum_q <= sum_q + {8'h00, rx_byte_s1};
				end
				4'd6: begin
					param_q[7:0] <= rx_byte_s1;
					if (covered) sum_q <= sum_q + {8'h00, rx_byte_s1};
				end
				4'd7: check_q[15:8] <= rx_byte_s1;
				4'd8: check_q[7:0]  <= rx_byte_s1;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_byte) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_byte) begin
			frame_ok_q    <= frame_ok;
			reply_cmd_q   <= cmd_q;
			reply_fb_q    <= feedback_q;
			reply_param_q <= param_q;
			action_q      <= action;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = frame_ok_q;
	assign m_tdata  = {6'b000000, action_q, reply_param_q, reply_fb_q, reply_cmd_q};

`ifndef ASSERT_OFF
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= prfc_pkg::LAST_POS)
		else $error("frame position out of range");

	a_action_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser || m_tdata[33:32] == prfc_pkg::ACT_NONE))
		else $error("action reported for a bad frame");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !advance) |-> (last_byte && m_tvalid && !m_tready))
		else $error("input stalled without a blocked report");

	a_pos_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_byte) |=> (byte_pos_q == 4'd0 && m_tvalid))
		else $error("tenth byte did not close the frame");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the audio module reply frame checker
// Streams reply-frame bytes into the block. Each byte is run through a frame
// model kept in the bench, and the model's frame reports are compared field
// by field with the reports the block delivers. A short table of frames comes
// first, then random frames (well-formed, spoiled, cut short, noise) under
// several sets of command codes, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic       first;
		logic       in_call;
		logic [7:0] idle;
		logic [7:0] rx;
	} rx_item_t;

	typedef struct packed {
		logic              ok;
		logic [7:0]        cmd;
		logic [7:0]        feedback;
		logic [15:0]       param;
		prfc_pkg::action_t action;
	} reply_t;

	typedef struct packed {
		rx_item_t item;
		logic     typed;
		reply_t   reply;
	} stim_row_t;

	localparam reply_t NO_REPLY = '{1'b0, 8'h00, 8'h00, 16'h0000, prfc_pkg::ACT_NONE};

	// power-on frame that asks for set volume, a cut-off start, then a frame of
	// all ones that restarts with frame_first and fails the start check
	localparam stim_row_t DIRECTED [23] = '{
		'{'{1'b1, 1'b0, 8'd0, 8'h7E}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b0, 8'd0, 8'hFF}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b0, 8'd0, 8'h06}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b0, 8'd0, 8'h3F}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b0, 8'd0, 8'h00}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b0, 8'd0, 8'h00}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b0, 8'd0, 8'h02}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b0, 8'd0, 8'hFE}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b0, 8'd0, 8'hBA}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b0, 8'd0, 8'hEF}, 1'b1,
			'{1'b1, 8'h3F, 8'h00, 16'h0002, prfc_pkg::ACT_SET_VOLUME}},
		'{'{1'b1, 1'b1, 8'd255, 8'h7E}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b1, 8'd255, 8'hFF}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b1, 8'd255, 8'h06}, 1'b0, NO_REPLY},
		'{'{1'b1, 1'b1, 8'd255, 8'hFF}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b1, 8'd255, 8'hFF}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b1, 8'd255, 8'hFF}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b1, 8'd255, 8'hFF}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b1, 8'd255, 8'hFF}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b1, 8'd255, 8'hFF}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b1, 8'd255, 8'hFF}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b1, 8'd255, 8'hFF}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b1, 8'd255, 8'hFF}, 1'b0, NO_REPLY},
		'{'{1'b0, 1'b1, 8'd255, 8'hFF}, 1'b1,
			'{1'b0, 8'hFF, 8'hFF, 16'hFFFF, prfc_pkg::ACT_NONE}}
	};

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata   = '0;   // [7:0] rx_byte, [15:8] idle_seconds, [16] in_call
	logic        s_tuser   = 1'b0; // [0] frame_first
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	// [7:0] reply_cmd, [15:8] reply_feedback, [31:16] reply_param, [33:32] action
	logic [39:0] m_tdata;
	logic        m_tuser;          // [0] frame_ok
	logic        cfg_we    = 1'b0;
	prfc_pkg::cfg_idx_t cfg_index = prfc_pkg::CFG_POWER_ON;
	logic [7:0]  cfg_data  = '0;

	// command codes as the block should hold them
	logic [7:0]  code_power_on = prfc_pkg::POWER_ON_RST;
	logic [7:0]  code_stopped  = prfc_pkg::STOPPED_RST;
	logic [7:0]  code_error    = prfc_pkg::ERROR_RST;

	// frame model state
	logic [3:0]  frame_pos      = '0;
	logic [15:0] frame_sum      = '0;
	logic [7:0]  frame_len      = '0;
	logic        frame_start_ok = 1'b0;
	logic [7:0]  frame_cmd      = '0;
	logic [7:0]  frame_fb       = '0;
	logic [15:0] frame_param    = '0;
	logic [15:0] frame_check    = '0;

	reply_t      pending_replies [$];
	int          mismatches  = 0;
	int          items_sent  = 0;
	int          cycle_count = 0;
	bit          idle_en     = 1'b1;
	bit          hold_req    = 1'b0;
	int          hold_left   = 0;
	int          stall_left  = 0;

	player_reply_frame_checker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// number of bytes after the start byte that the checksum covers
	function automatic logic [7:0] sum_span(input logic [7:0] len);
		return (len > prfc_pkg::MAX_SUM_LEN) ? 8'(prfc_pkg::MAX_SUM_LEN) : len;
	endfunction

	// advance the frame model by one byte; returns 1 when a report is due
	function automatic bit frame_step(input rx_item_t it, output reply_t rep);
		logic [3:0]  pos;
		logic [15:0] want_check;
		rep = NO_REPLY;
		if (it.first)
			frame_pos = '0;
		pos = frame_pos;
		case (pos)
			4'd0: begin
				frame_start_ok = (it.rx == prfc_pkg::START_HI);
				frame_sum = '0;
			end
			4'd1: frame_start_ok = frame_start_ok && (it.rx == prfc_pkg::START_LO);
			4'd2: begin
				frame_len = it.rx;
				// byte 1 enters the sum as the start marker, not as received
				frame_sum = '0;
				if (sum_span(it.rx) >= 1)
					frame_sum = frame_sum + {8'h00, prfc_pkg::START_LO};
				if (sum_span(it.rx) >= 2)
					frame_sum = frame_sum + {8'h00, it.rx};
			end
			4'd3, 4'd4, 4'd5, 4'd6: begin
				case (pos)
					4'd3: frame_cmd = it.rx;
					4'd4: frame_fb = it.rx;
					4'd5: frame_param[15:8] = it.rx;
					default: frame_param[7:0] = it.rx;
				endcase
				if (pos <= sum_span(frame_len))
					frame_sum = frame_sum + {8'h00, it.rx};
			end
			4'd7: frame_check[15:8] = it.rx;
			4'd8: frame_check[7:0] = it.rx;
			default: ;
		endcase
		if (pos >= prfc_pkg::LAST_POS) begin
			want_check = 16'd0 - frame_sum;
			rep.ok = frame_start_ok && (it.rx == prfc_pkg::END_MARK)
				&& (want_check == frame_check);
			rep.cmd = frame_cmd;
			rep.feedback = frame_fb;
			rep.param = frame_param;
			rep.action = prfc_pkg::ACT_NONE;
			if (rep.ok) begin
				if (frame_cmd == code_power_on)
					rep.action = (frame_param[7:0] != prfc_pkg::SETMODE_PARAM)
						? prfc_pkg::ACT_SET_MODE : prfc_pkg::ACT_SET_VOLUME;
				else if (frame_cmd == code_stopped)
					rep.action = ((it.idle > 0 && it.idle <= prfc_pkg::IDLE_LIMIT)
						|| !it.in_call) ? prfc_pkg::ACT_AMP_OFF : prfc_pkg::ACT_NONE;
				else if (frame_cmd == code_error)
					rep.action = prfc_pkg::ACT_AMP_OFF;
			end
			frame_pos = '0;
			return 1'b1;
		end
		frame_pos = pos + 4'd1;
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] want,
		input logic [15:0] got);
		$display("ERROR at %0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
		mismatches++;
	endtask

	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[31:16],
				prfc_pkg::action_t'(m_tdata[33:32])};
			if (pending_replies.size() == 0) begin
				report_mismatch("unexpected report, cmd", 16'd0, 16'(got.cmd));
			end else begin
				want = pending_replies.pop_front();
				if (got.ok !== want.ok)
					report_mismatch("frame_ok", 16'(want.ok), 16'(got.ok));
				if (got.cmd !== want.cmd)
					report_mismatch("reply_cmd", 16'(want.cmd), 16'(got.cmd));
				if (got.feedback !== want.feedback)
					report_mismatch("reply_feedback", 16'(want.feedback),
						16'(got.feedback));
				if (got.param !== want.param)
					report_mismatch("reply_param", want.param, got.param);
				if (got.action !== want.action)
					report_mismatch("action", 16'(want.action), 16'(got.action));
			end
		end
	end

	// receiver: random stall bursts, plus one long hold on request
	always @(negedge clk) begin
		logic ready_nxt;
		ready_nxt = 1'b1;
		if (hold_req && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			ready_nxt = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			ready_nxt = 1'b0;
		end else if (idle_en && $urandom_range(3) == 0) begin
			stall_left = $urandom_range(3);
			ready_nxt = 1'b0;
		end
		m_tready <= ready_nxt;
	end

	// offer one byte, wait for the transaction, then drop valid at the next
	// falling edge unless the caller offers another byte in the same step
	task automatic send_item(input rx_item_t it, input logic typed, input reply_t typed_rep);
		reply_t rep;
		if (idle_en && !hold_req && hold_left == 0 && $urandom_range(3) == 0)
			repeat ($urandom_range(1, 4)) @(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {7'd0, it.in_call, it.idle, it.rx};
		s_tuser = it.first;
		do @(posedge clk); while (!s_tready);
		if (frame_step(it, rep))
			pending_replies.push_back(typed ? typed_rep : rep);
		items_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic write_reg(input prfc_pkg::cfg_idx_t idx, input logic [7:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			prfc_pkg::CFG_POWER_ON: code_power_on = val;
			prfc_pkg::CFG_STOPPED:  code_stopped = val;
			prfc_pkg::CFG_ERROR:    code_error = val;
			default: ;
		endcase
	endtask

	task automatic write_codes(input logic [7:0] pwr, input logic [7:0] stp,
		input logic [7:0] err);
		write_reg(prfc_pkg::CFG_POWER_ON, pwr);
		write_reg(prfc_pkg::CFG_STOPPED, stp);
		write_reg(prfc_pkg::CFG_ERROR, err);
	endtask

	// hold the input until every report is in and the pipeline is empty
	task automatic settle();
		while (pending_replies.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_frame(input bit spoil);
		logic [7:0]  fb [10];
		logic [7:0]  len;
		logic [15:0] sum;
		rx_item_t    it;
		int          stop_at;
		case ($urandom_range(7))
			0: len = 8'($urandom_range(0, 5));
			1: len = 8'($urandom_range(7, 255));
			default: len = 8'(prfc_pkg::MAX_SUM_LEN);
		endcase
		fb[0] = prfc_pkg::START_HI;
		fb[1] = prfc_pkg::START_LO;
		fb[2] = len;
		case ($urandom_range(3))
			0: fb[3] = code_power_on;
			1: fb[3] = code_stopped;
			2: fb[3] = code_error;
			default: fb[3] = 8'($urandom_range(255));
		endcase
		fb[4] = 8'($urandom_range(255));
		fb[5] = 8'($urandom_range(255));
		fb[6] = ($urandom_range(3) == 0) ? prfc_pkg::SETMODE_PARAM
			: 8'($urandom_range(255));
		sum = '0;
		for (int k = 1; k <= 6; k++)
			if (k <= sum_span(len))
				sum = sum + {8'h00, fb[k]};
		{fb[7], fb[8]} = 16'd0 - sum;
		fb[9] = prfc_pkg::END_MARK;
		stop_at = 10;
		if (spoil) begin
			if ($urandom_range(1))
				stop_at = $urandom_range(1, 9);
			else
				fb[$urandom_range(9)] ^= 8'(8'h01 << $urandom_range(7));
		end
		for (int k = 0; k < stop_at; k++) begin
			it.rx = fb[k];
			// force a restart when the model is out of step with the frame
			if (k == 0)
				it.first = (frame_pos != 0) || ($urandom_range(1) == 1);
			else
				it.first = spoil && ($urandom_range(15) == 0);
			if (k == 9 && $urandom_range(3) != 0)
				it.idle = 8'($urandom_range(0, 5));
			else
				it.idle = 8'($urandom_range(255));
			it.in_call = 1'($urandom_range(1));
			send_item(it, 1'b0, NO_REPLY);
		end
	endtask

	task automatic run_random(input int target);
		rx_item_t it;
		while (items_sent < target) begin
			case ($urandom_range(9))
				0: begin
					repeat ($urandom_range(1, 12)) begin
						it.rx = 8'($urandom_range(255));
						it.first = ($urandom_range(7) == 0);
						it.idle = 8'($urandom_range(255));
						it.in_call = 1'($urandom_range(1));
						send_item(it, 1'b0, NO_REPLY);
					end
				end
				1, 2:    send_frame(1'b1);
				default: send_frame(1'b0);
			endcase
		end
	endtask

	initial begin
		logic [7:0] same_code;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[r])
			send_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].reply);

		settle();
		write_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)));
		write_reg(prfc_pkg::CFG_UNUSED, 8'($urandom_range(255)));
		run_random(420);

		// stopped and error collide; stopped must win
		settle();
		write_codes(8'h00, 8'hFF, 8'hFF);
		run_random(800);

		// all three collide; power-on must win
		settle();
		same_code = 8'($urandom_range(255));
		write_codes(same_code, same_code, same_code);
		run_random(1150);

		// long receiver hold while the sender keeps offering bytes
		settle();
		write_codes(8'hFF, 8'h00, 8'h80);
		hold_req = 1'b1;
		repeat (6) send_frame(1'b0);
		run_random(1550);

		// back to reset codes, no idling on either side
		settle();
		write_codes(prfc_pkg::POWER_ON_RST, prfc_pkg::STOPPED_RST, prfc_pkg::ERROR_RST);
		idle_en = 1'b0;
		run_random(1950);

		settle();
		repeat (2 * DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
